>>> sv/mexp_pkg.sv
package mexp_pkg;

  // field widths
  localparam int BaseW = 32;
  localparam int ExpW  = 63;
  localparam int ModW  = 31;

  // modulus after reset (one billion seven)
  localparam logic [ModW-1:0] ModulusReset = 31'd1000000007;

endpackage

>>> sv/mexp_ifs.sv
// operand channel: base and exponent
interface mexp_operand_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::BaseW-1:0]    base_value;
  logic [mexp_pkg::ExpW-1:0]     exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

// result channel
interface mexp_result_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::ModW-1:0]     power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

// modulus write channel
interface mexp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::ModW-1:0]     modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

>>> sv/modular_exponentiation_unit.sv
// channel   dir  payload                         handshake
// operand   in   base_value[31:0], exponent[62:0] valid/ready
// result    out  power_result[30:0]              valid/ready
// cfg       in   modulus[30:0]                   valid/ready, always ready
//
// One shared interleaved modular multiplier retires one multiplier bit per
// cycle; it reduces the base, multiplies into the result and squares.
// Reset is synchronous; the modulus returns to 1000000007.
// The operand side is ready only when the sequencer is idle; a finished
// result waits in the output register while the next item is taken.
module modular_exponentiation_unit (
  input  logic clk,
  input  logic rst,
  mexp_operand_if.sink operand,
  mexp_result_if.source result,
  mexp_cfg_if.sink cfg
);

  localparam int ModW  = mexp_pkg::ModW;
  localparam int BaseW = mexp_pkg::BaseW;
  localparam int ExpW  = mexp_pkg::ExpW;
  localparam int CntW  = $clog2(BaseW);

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPick = 3'd1;
  localparam logic [2:0] StRun  = 3'd2;
  localparam logic [2:0] StDone = 3'd3;

  logic [2:0]       state;
  logic [ModW-1:0]  modulus;
  logic [ModW-1:0]  acc;
  logic [ModW-1:0]  sq;
  logic [ExpW-1:0]  exp_left;
  logic             dest_acc;

  // shared multiplier operands
  logic [ModW-1:0]  ux;
  logic [BaseW-1:0] uy;
  logic [ModW-1:0]  ur;
  logic [CntW-1:0]  ucnt;

  logic [ModW+1:0]  r2;
  logic [ModW+1:0]  m1;
  logic [ModW+1:0]  m2;
  logic [ModW-1:0]  ur_next;

  // modulus register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mexp_pkg::ModulusReset;
    end else if (cfg.valid) begin
      modulus <= cfg.modulus;
    end
  end

  // one step: r = 2r + bit*x, then bring below m (r2 < 3m)
  always_comb begin
    m1 = {2'b00, modulus};
    m2 = {1'b0, modulus, 1'b0};
    r2 = {1'b0, ur, 1'b0} + (uy[BaseW-1] ? {2'b00, ux} : '0);
    if (r2 >= m2) begin
      ur_next = ModW'(r2 - m2);
    end else if (r2 >= m1) begin
      ur_next = ModW'(r2 - m1);
    end else begin
      ur_next = ModW'(r2);
    end
  end

  assign operand.ready = (state == StIdle);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= StIdle;
      result.valid <= 1'b0;
    end else begin
      // output register: load a finished power, or empty it once taken
      if (state == StDone && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (operand.valid) begin
            exp_left <= operand.exponent;
            if (modulus < ModW'(2)) begin
              acc   <= '0;
              state <= StDone;
            end else begin
              // reduce base: base * 1 mod m, result into sq
              acc      <= ModW'(1);
              ux       <= ModW'(1);
              uy       <= operand.base_value;
              ur       <= '0;
              ucnt     <= '0;
              dest_acc <= 1'b0;
              state    <= StRun;
            end
          end
        end
        StPick: begin
          ur   <= '0;
          ucnt <= '0;
          if (exp_left == '0) begin
            state <= StDone;
          end else if (exp_left[0]) begin
            // multiply running power into result
            ux          <= acc;
            uy          <= {1'b0, sq};
            dest_acc    <= 1'b1;
            exp_left[0] <= 1'b0;
            state       <= StRun;
          end else begin
            // square and move to the next exponent bit
            ux       <= sq;
            uy       <= {1'b0, sq};
            dest_acc <= 1'b0;
            exp_left <= exp_left >> 1;
            state    <= StRun;
          end
        end
        StRun: begin
          ur   <= ur_next;
          uy   <= uy << 1;
          ucnt <= ucnt + CntW'(1);
          if (ucnt == CntW'(BaseW - 1)) begin
            if (dest_acc) begin
              acc <= ur_next;
            end else begin
              sq <= ur_next;
            end
            state <= StPick;
          end
        end
        StDone: begin
          if (!result.valid || result.ready) begin
            result.power_result <= acc;
            state               <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule
